// ===== design/assert_macros.svh =====
// assertion macros shared by the sector frame handler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SSFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define SSFH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/ssfh_pkg.sv =====
// types and constants of the serial sector frame handler
package ssfh_pkg;

  localparam logic [7:0] TOK_FIRST  = 8'hAA;
  localparam logic [7:0] TOK_SECOND = 8'h55;
  localparam logic [7:0] ACK_FIRST  = 8'hCC;
  localparam logic [7:0] ACK_SECOND = 8'hEE;
  localparam logic [7:0] OP_READ    = 8'd5;
  localparam logic [7:0] OP_WRITE   = 8'd6;

  localparam logic SRC_SERIAL = 1'b0;
  localparam logic SRC_STORE  = 1'b1;

  localparam int OFFSET_W   = 21;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // result kinds as seen on the output port
  typedef enum logic [2:0] {
    RES_READ_REQ   = 3'd0,
    RES_WRITE_REQ  = 3'd1,
    RES_BAD_OP     = 3'd2,
    RES_TX_BYTE    = 3'd3,
    RES_WRITE_DATA = 3'd4,
    RES_WRITE_END  = 3'd5
  } res_kind_t;

  // commands from front to back, each expands to one to three results
  typedef enum logic [2:0] {
    CMD_READ_REQ,
    CMD_WRITE_REQ,
    CMD_BAD_OP,
    CMD_TX_BYTE,
    CMD_TX_LAST,
    CMD_WRITE_DATA,
    CMD_WRITE_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [7:0]          data;
    logic [7:0]          aux;
    logic [7:0]          drive;
    logic [7:0]          track;
    logic [7:0]          sector;
    logic [OFFSET_W-1:0] offset;
    logic                present;
  } cmd_t;

  typedef struct packed {
    res_kind_t           kind;
    logic [7:0]          value;
    logic [7:0]          drive;
    logic [7:0]          track;
    logic [7:0]          sector;
    logic [OFFSET_W-1:0] offset;
    logic                present;
    logic                check_ok;
    logic                last;
  } res_t;

endpackage

// ===== design/serial_sector_frame_handler_unit.sv =====
// top level of the serial sector frame handler
//
// host side of a serial disk-sector link. input words are either serial line
// bytes (operation 0) or storage bytes (operation 1). the front end hunts the
// tokens 0xAA 0x55, takes a five byte header (drive, operation, track, sector,
// check) and classifies every word into a command; the back end expands each
// command into result words. a read request gives three results (request,
// 0xCC, 0xEE), each storage byte of the reply one result and the last one two
// (byte and xor check); a write request gives one result, then one write data
// result per serial byte and a write end with the commit flag. words that
// cause no result (token hunt, header bytes, serial bytes during a read reply,
// stray storage bytes) are simply consumed. one input word is taken per clock
// as long as the four entry command queue has room; results leave at one per
// clock from the output register while pop is held, so over a long run the
// result side pop rate sets the pace and full rises when the queue backs up.
// the single register, the drive present mask, is written through the cfg
// port, which is always ready; write it only while the block is idle.
module serial_sector_frame_handler_unit import ssfh_pkg::*; #(
  parameter int SECTOR_BYTES      = 256,
  parameter int SECTORS_PER_TRACK = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // input word queue side
  input  logic                push,
  output logic                full,
  input  logic                in_operation,
  input  logic [7:0]          in_byte_value,
  // result word queue side
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          out_kind,
  output logic [7:0]          out_byte_value_res,
  output logic [7:0]          out_drive,
  output logic [7:0]          out_track,
  output logic [7:0]          out_sector,
  output logic [OFFSET_W-1:0] out_byte_offset,
  output logic                out_drive_present,
  output logic                out_check_ok,
  output logic                out_last,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_drive_present_mask
);

  logic [3:0] mask_r;
  logic       accept;
  logic       q_full;
  logic       f_cmd_valid;
  cmd_t       f_cmd;
  logic       q_avail;
  cmd_t       q_head;
  logic       q_pop;
  logic       b_valid;
  res_t       b_res;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 4'd0;
    end else if (cfg_valid) begin
      mask_r <= cfg_drive_present_mask;
    end
  end

  // input word is taken whenever the command queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  ssfh_front #(
    .SECTOR_BYTES      (SECTOR_BYTES),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_operation  (in_operation),
    .in_byte_value (in_byte_value),
    .mask          (mask_r),
    .cmd_valid     (f_cmd_valid),
    .cmd           (f_cmd)
  );

  // commands queue up here so front and back stall on their own
  ssfh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_cmd_valid),
    .push_cmd (f_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  ssfh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_avail (q_avail),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_take  (pop),
    .out_valid (b_valid),
    .res       (b_res)
  );

  // result word fields straight from the output register
  assign empty              = !b_valid;
  assign out_kind           = b_res.kind;
  assign out_byte_value_res = b_res.value;
  assign out_drive          = b_res.drive;
  assign out_track          = b_res.track;
  assign out_sector         = b_res.sector;
  assign out_byte_offset    = b_res.offset;
  assign out_drive_present  = b_res.present;
  assign out_check_ok       = b_res.check_ok;
  assign out_last           = b_res.last;

endmodule

// ===== design/ssfh_front.sv =====
// front end: token hunt, header capture and per-word classification
`include "assert_macros.svh"

module ssfh_front import ssfh_pkg::*; #(
  parameter int SECTOR_BYTES      = 256,
  parameter int SECTORS_PER_TRACK = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       in_operation,
  input  logic [7:0] in_byte_value,
  input  logic [3:0] mask,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  localparam int CW  = $clog2(SECTOR_BYTES + 1);
  localparam int TMW = 8 + $clog2(SECTORS_PER_TRACK + 1);
  localparam logic [CW-1:0]  SB_C       = CW'(SECTOR_BYTES);
  localparam logic [TMW-1:0] SPT_C      = TMW'(SECTORS_PER_TRACK);
  localparam logic [CW-1:0]  HDR_DRIVE  = CW'(0);
  localparam logic [CW-1:0]  HDR_OP     = CW'(1);
  localparam logic [CW-1:0]  HDR_TRACK  = CW'(2);
  localparam logic [CW-1:0]  HDR_SECTOR = CW'(3);
  localparam logic [CW-1:0]  HDR_CHECK  = CW'(4);

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_HEADER,
    PH_READ,
    PH_WRITE
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [7:0]          chk_r, chk_nxt;
  logic [7:0]          drive_r, drive_nxt;
  logic [7:0]          op_r, op_nxt;
  logic [7:0]          track_r, track_nxt;
  logic [7:0]          sector_r, sector_nxt;
  logic [TMW-1:0]      tmul_r, tmul_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;

  logic                present;
  logic [7:0]          store_byte;
  logic [CW-1:0]       cnt_inc;
  logic [TMW:0]        lin_sector;
  logic [31:0]         prod;

  assign present    = (drive_r[7:2] == 6'd0) && mask[drive_r[1:0]];
  assign store_byte = present ? in_byte_value : 8'd0;
  assign cnt_inc    = cnt_r + 1'b1;
  assign lin_sector = {1'b0, tmul_r} + (TMW + 1)'(in_byte_value);
  assign prod       = 32'(lin_sector) * 32'(SECTOR_BYTES);

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    chk_nxt     = chk_r;
    drive_nxt   = drive_r;
    op_nxt      = op_r;
    track_nxt   = track_r;
    sector_nxt  = sector_r;
    tmul_nxt    = tmul_r;
    offset_nxt  = offset_r;
    cmd_valid   = 1'b0;
    cmd.kind    = CMD_BAD_OP;
    cmd.data    = 8'd0;
    cmd.aux     = 8'd0;
    cmd.drive   = drive_r;
    cmd.track   = track_r;
    cmd.sector  = sector_r;
    cmd.offset  = offset_r;
    cmd.present = present;
    if (accept) begin
      if (in_operation == SRC_STORE) begin
        if (phase_r == PH_READ) begin
          chk_nxt   = chk_r ^ store_byte;
          cmd_valid = 1'b1;
          cmd.data  = store_byte;
          if (cnt_inc >= SB_C) begin
            cmd.kind  = CMD_TX_LAST;
            cmd.aux   = chk_r ^ store_byte;
            phase_nxt = PH_HUNT1;
            cnt_nxt   = '0;
          end else begin
            cmd.kind = CMD_TX_BYTE;
            cnt_nxt  = cnt_inc;
          end
        end
      end else begin
        unique case (phase_r)
          PH_HUNT1: begin
            if (in_byte_value == TOK_FIRST) phase_nxt = PH_HUNT2;
          end
          PH_HUNT2: begin
            if (in_byte_value == TOK_SECOND) begin
              phase_nxt = PH_HEADER;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = PH_HUNT1;
            end
          end
          PH_HEADER: begin
            if (cnt_r == HDR_DRIVE) drive_nxt = in_byte_value;
            if (cnt_r == HDR_OP) op_nxt = in_byte_value;
            if (cnt_r == HDR_TRACK) begin
              track_nxt = in_byte_value;
              tmul_nxt  = TMW'(in_byte_value) * SPT_C;
            end
            if (cnt_r == HDR_SECTOR) begin
              sector_nxt = in_byte_value;
              offset_nxt = prod[OFFSET_W-1:0];
            end
            if (cnt_r == HDR_CHECK) begin
              cnt_nxt   = '0;
              cmd_valid = 1'b1;
              if (op_r == OP_READ) begin
                chk_nxt   = ACK_FIRST ^ ACK_SECOND;
                phase_nxt = PH_READ;
                cmd.kind  = CMD_READ_REQ;
              end else if (op_r == OP_WRITE) begin
                chk_nxt   = 8'd0;
                phase_nxt = PH_WRITE;
                cmd.kind  = CMD_WRITE_REQ;
              end else begin
                phase_nxt = PH_HUNT1;
                cmd.kind  = CMD_BAD_OP;
              end
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_WRITE: begin
            cmd_valid = 1'b1;
            cmd.data  = in_byte_value;
            if (cnt_r < SB_C) begin
              chk_nxt  = chk_r ^ in_byte_value;
              cnt_nxt  = cnt_inc;
              cmd.kind = CMD_WRITE_DATA;
            end else begin
              cmd.kind  = CMD_WRITE_END;
              cmd.aux   = {7'd0, (chk_r == in_byte_value) && present};
              phase_nxt = PH_HUNT1;
              cnt_nxt   = '0;
            end
          end
          PH_READ: begin
            // serial words during a read reply are dropped
          end
          default: begin
            phase_nxt = PH_HUNT1;
            cnt_nxt   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT1;
      cnt_r    <= '0;
      chk_r    <= 8'd0;
      drive_r  <= 8'd0;
      op_r     <= 8'd0;
      track_r  <= 8'd0;
      sector_r <= 8'd0;
      tmul_r   <= '0;
      offset_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      chk_r    <= chk_nxt;
      drive_r  <= drive_nxt;
      op_r     <= op_nxt;
      track_r  <= track_nxt;
      sector_r <= sector_nxt;
      tmul_r   <= tmul_nxt;
      offset_r <= offset_nxt;
    end
  end

  `SSFH_ASSERT(a_hdr_cnt, (phase_r != PH_HEADER) || (cnt_r <= HDR_CHECK), "header count overrun")
  `SSFH_ASSERT(a_data_cnt, (phase_r == PH_HEADER) || (cnt_r < SB_C) || (phase_r == PH_WRITE && cnt_r == SB_C), "sector count overrun")

endmodule

// ===== design/ssfh_queue.sv =====
// short command queue between front and back
`include "assert_macros.svh"

module ssfh_queue import ssfh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t               mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_AW:0]   count_r;

  assign full  = (count_r == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign avail = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `SSFH_NEVER(a_q_overflow, push && full, "command queue overflow")
  `SSFH_NEVER(a_q_underflow, pop && !avail, "command queue underflow")

endmodule

// ===== design/ssfh_back.sv =====
// back end: expands commands into result words behind an output register
`include "assert_macros.svh"

module ssfh_back import ssfh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_avail,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic out_take,
  output logic out_valid,
  output res_t res
);

  logic [1:0] idx_r;
  logic [1:0] last_idx;
  logic       out_valid_r;
  res_t       res_r;
  res_t       res_nxt;
  logic       adv;
  logic       take;

  always_comb begin
    unique case (cmd.kind)
      CMD_READ_REQ: last_idx = 2'd2;
      CMD_TX_LAST:  last_idx = 2'd1;
      default:      last_idx = 2'd0;
    endcase
  end

  assign adv     = !out_valid_r || out_take;
  assign take    = adv && cmd_avail;
  assign cmd_pop = take && (idx_r == last_idx);

  always_comb begin
    res_nxt.drive    = cmd.drive;
    res_nxt.track    = cmd.track;
    res_nxt.sector   = cmd.sector;
    res_nxt.offset   = cmd.offset;
    res_nxt.present  = cmd.present;
    res_nxt.check_ok = 1'b0;
    res_nxt.last     = (idx_r == last_idx);
    res_nxt.value    = 8'd0;
    res_nxt.kind     = RES_BAD_OP;
    unique case (cmd.kind)
      CMD_READ_REQ: begin
        if (idx_r == 2'd0) begin
          res_nxt.kind = RES_READ_REQ;
        end else begin
          res_nxt.kind  = RES_TX_BYTE;
          res_nxt.value = (idx_r == 2'd1) ? ACK_FIRST : ACK_SECOND;
        end
      end
      CMD_WRITE_REQ: res_nxt.kind = RES_WRITE_REQ;
      CMD_BAD_OP:    res_nxt.kind = RES_BAD_OP;
      CMD_TX_BYTE: begin
        res_nxt.kind  = RES_TX_BYTE;
        res_nxt.value = cmd.data;
      end
      CMD_TX_LAST: begin
        res_nxt.kind  = RES_TX_BYTE;
        res_nxt.value = (idx_r == 2'd0) ? cmd.data : cmd.aux;
      end
      CMD_WRITE_DATA: begin
        res_nxt.kind  = RES_WRITE_DATA;
        res_nxt.value = cmd.data;
      end
      CMD_WRITE_END: begin
        res_nxt.kind     = RES_WRITE_END;
        res_nxt.value    = cmd.data;
        res_nxt.check_ok = cmd.aux[0];
      end
      default: res_nxt.kind = RES_BAD_OP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (adv) out_valid_r <= cmd_avail;
      if (take) idx_r <= (idx_r == last_idx) ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  `SSFH_ASSERT(a_idx_range, !cmd_avail || (idx_r <= last_idx), "result index past command end")
  `SSFH_ASSERT(a_idle_idx, cmd_avail || (idx_r == 2'd0), "result index left open without command")

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the serial sector frame handler top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssfh_pkg::*;

  // geometry used by the bench instance, same as the block defaults
  localparam int SECTOR_BYTES      = 256;
  localparam int SECTORS_PER_TRACK = 16;
  localparam int HEADER_LEN        = 5;
  localparam int RESET_CYCLES      = 12;
  // command queue plus output register, with margin
  localparam int DRAIN_TAIL        = 16;
  localparam int FRAMES_PER_MASK   = 2;
  localparam int MASK_SETTINGS     = 5;
  // payload words of the final frame, well short of a sector
  localparam int OPEN_PAYLOAD      = 24;
  localparam int CYCLE_LIMIT       = 100000;

  // link state as the bench tracks it
  typedef enum logic [2:0] {
    LP_HUNT_FIRST,
    LP_HUNT_SECOND,
    LP_TAKE_HEADER,
    LP_READ_REPLY,
    LP_WRITE_DATA
  } link_phase_t;

  // one row of the directed table; exp only used when pinned is set
  typedef struct packed {
    logic op;
    logic [7:0] val;
    logic pinned;
    res_t exp;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                in_operation = 1'b0;
  logic [7:0]          in_byte_value = 8'h00;
  logic                pop = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [3:0]          cfg_drive_present_mask = 4'h0;
  logic                full;
  logic                empty;
  logic [2:0]          out_kind;
  logic [7:0]          out_byte_value_res;
  logic [7:0]          out_drive;
  logic [7:0]          out_track;
  logic [7:0]          out_sector;
  logic [OFFSET_W-1:0] out_byte_offset;
  logic                out_drive_present;
  logic                out_check_ok;
  logic                out_last;
  logic                cfg_ready;

  // travels with push so the checker knows a pinned row was taken
  logic row_pinned = 1'b0;
  res_t row_exp = '0;

  // bench copy of the link state, reset values
  link_phase_t lp_phase = LP_HUNT_FIRST;
  int unsigned lp_count = 0;
  logic [7:0]  hdr_drive = 8'h00;
  logic [7:0]  hdr_op = 8'h00;
  logic [7:0]  hdr_track = 8'h00;
  logic [7:0]  hdr_sector = 8'h00;
  logic [7:0]  lp_xor = 8'h00;
  logic [3:0]  mounted_mask = 4'h0;

  res_t      step_results[$];   // results of the word just taken
  res_t      awaited[$];        // results still owed by the block
  stim_row_t stim_rows[$];
  int        fail_count = 0;
  bit        steady = 1'b0;     // no sender gaps for the current frame
  int        cycle_count = 0;

  serial_sector_frame_handler_unit #(
    .SECTOR_BYTES      (SECTOR_BYTES),
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
  ) u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .push                   (push),
    .full                   (full),
    .in_operation           (in_operation),
    .in_byte_value          (in_byte_value),
    .empty                  (empty),
    .pop                    (pop),
    .out_kind               (out_kind),
    .out_byte_value_res     (out_byte_value_res),
    .out_drive              (out_drive),
    .out_track              (out_track),
    .out_sector             (out_sector),
    .out_byte_offset        (out_byte_offset),
    .out_drive_present      (out_drive_present),
    .out_check_ok           (out_check_ok),
    .out_last               (out_last),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_drive_present_mask (cfg_drive_present_mask)
  );

  // 2 ns clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic res_t mk_res(res_kind_t kind, logic [7:0] value, logic [7:0] drv,
                                  logic [7:0] trk, logic [7:0] sec,
                                  logic [OFFSET_W-1:0] off, logic present,
                                  logic ok, logic last);
    res_t r;
    r.kind     = kind;
    r.value    = value;
    r.drive    = drv;
    r.track    = trk;
    r.sector   = sec;
    r.offset   = off;
    r.present  = present;
    r.check_ok = ok;
    r.last     = last;
    return r;
  endfunction

  // only drives 0..3 can be mounted
  function automatic logic drive_mounted();
    return (hdr_drive < 8'd4) && mounted_mask[hdr_drive[1:0]];
  endfunction

  // one result stamped with the current header
  task automatic note_result(res_kind_t kind, logic [7:0] value, logic ok, logic last);
    logic [31:0] off;
    off = (int'(hdr_track) * SECTORS_PER_TRACK + int'(hdr_sector)) * SECTOR_BYTES;
    step_results.push_back(mk_res(kind, value, hdr_drive, hdr_track, hdr_sector,
                                  off[OFFSET_W-1:0], drive_mounted(), ok, last));
  endtask

  // advance the link state by one word and collect what it yields
  task automatic predict_word(logic from_store, logic [7:0] b);
    logic [7:0] v;
    logic ok;
    step_results.delete();
    if (from_store == SRC_STORE) begin
      // storage bytes only matter inside a read reply
      if (lp_phase == LP_READ_REPLY) begin
        v = drive_mounted() ? b : 8'h00;
        lp_xor ^= v;
        lp_count++;
        if (lp_count >= SECTOR_BYTES) begin
          note_result(RES_TX_BYTE, v, 1'b0, 1'b0);
          note_result(RES_TX_BYTE, lp_xor, 1'b0, 1'b1);
          lp_phase = LP_HUNT_FIRST;
          lp_count = 0;
        end else begin
          note_result(RES_TX_BYTE, v, 1'b0, 1'b1);
        end
      end
    end else begin
      case (lp_phase)
        LP_HUNT_FIRST: begin
          if (b == TOK_FIRST) lp_phase = LP_HUNT_SECOND;
        end
        LP_HUNT_SECOND: begin
          // a wrong second token is not retried as a first token
          if (b == TOK_SECOND) begin
            lp_phase = LP_TAKE_HEADER;
            lp_count = 0;
          end else begin
            lp_phase = LP_HUNT_FIRST;
          end
        end
        LP_TAKE_HEADER: begin
          case (lp_count)
            0: hdr_drive = b;
            1: hdr_op = b;
            2: hdr_track = b;
            3: hdr_sector = b;
            default: ;  // check byte is taken but never tested
          endcase
          lp_count++;
          if (lp_count == HEADER_LEN) begin
            lp_count = 0;
            if (hdr_op == OP_READ) begin
              lp_xor = ACK_FIRST ^ ACK_SECOND;
              lp_phase = LP_READ_REPLY;
              note_result(RES_READ_REQ, 8'h00, 1'b0, 1'b0);
              note_result(RES_TX_BYTE, ACK_FIRST, 1'b0, 1'b0);
              note_result(RES_TX_BYTE, ACK_SECOND, 1'b0, 1'b1);
            end else if (hdr_op == OP_WRITE) begin
              lp_xor = 8'h00;
              lp_phase = LP_WRITE_DATA;
              note_result(RES_WRITE_REQ, 8'h00, 1'b0, 1'b1);
            end else begin
              lp_phase = LP_HUNT_FIRST;
              note_result(RES_BAD_OP, 8'h00, 1'b0, 1'b1);
            end
          end
        end
        LP_WRITE_DATA: begin
          if (lp_count < SECTOR_BYTES) begin
            lp_xor ^= b;
            lp_count++;
            note_result(RES_WRITE_DATA, b, 1'b0, 1'b1);
          end else begin
            // trailing byte: commit only on matching xor and a mounted drive
            ok = (lp_xor == b) ? drive_mounted() : 1'b0;
            note_result(RES_WRITE_END, b, ok, 1'b1);
            lp_phase = LP_HUNT_FIRST;
            lp_count = 0;
          end
        end
        default: ;  // serial bytes during a read reply are dropped
      endcase
    end
  endtask

  task automatic field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // checker: results against the oldest expectation, then new words,
  // then mask writes; everything is sampled at the rising edge
  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        got = mk_res(res_kind_t'(out_kind), out_byte_value_res, out_drive, out_track,
                     out_sector, out_byte_offset, out_drive_present, out_check_ok,
                     out_last);
        if (awaited.size() == 0) begin
          $display("%0t result expected none actual kind %0d value %0h", $time,
                   out_kind, out_byte_value_res);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          field_check("kind", want.kind, got.kind);
          field_check("byte_value_res", want.value, got.value);
          field_check("drive", want.drive, got.drive);
          field_check("track", want.track, got.track);
          field_check("sector", want.sector, got.sector);
          field_check("byte_offset", want.offset, got.offset);
          field_check("drive_present", want.present, got.present);
          field_check("check_ok", want.check_ok, got.check_ok);
          field_check("last", want.last, got.last);
        end
      end
      if (push && !full) begin
        predict_word(in_operation, in_byte_value);
        // pinned rows carry their own expectation, the model still advances
        if (row_pinned) awaited.push_back(row_exp);
        else foreach (step_results[i]) awaited.push_back(step_results[i]);
      end
      if (cfg_valid && cfg_ready) mounted_mask = cfg_drive_present_mask;
    end
  end

  // result side: bursts of pop, short stalls, now and then a long one
  initial begin : result_sink
    int sel;
    int n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        pop <= 1'b1;
        n = $urandom_range(1, 24);
      end else if (sel < 9) begin
        pop <= 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        pop <= 1'b0;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  // offer one word and hold it until taken; called at a rising edge
  task automatic put_word(logic op, logic [7:0] val, logic pinned, res_t exp);
    push <= 1'b1;
    in_operation <= op;
    in_byte_value <= val;
    row_pinned <= pinned;
    row_exp <= exp;
    do @(posedge clk); while (full);
  endtask

  // sender gap after a word, mostly none or short
  task automatic idle_gap();
    int sel;
    int n;
    sel = $urandom_range(0, 19);
    if (steady || sel < 12) n = 0;
    else if (sel < 18) n = $urandom_range(1, 3);
    else if (sel < 19) n = $urandom_range(4, 10);
    else n = $urandom_range(15, 40);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic feed(logic op, logic [7:0] val);
    put_word(op, val, 1'b0, '0);
    idle_gap();
  endtask

  // push filler until the link is back to hunting; phase read at the falling edge
  task automatic settle();
    push <= 1'b0;
    @(negedge clk);
    while (lp_phase != LP_HUNT_FIRST) begin
      @(posedge clk);
      if (lp_phase == LP_READ_REPLY) put_word(SRC_STORE, 8'($urandom), 1'b0, '0);
      else put_word(SRC_SERIAL, 8'($urandom), 1'b0, '0);
      push <= 1'b0;
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // hold off until every owed result is out, then let the pipe go quiet
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (awaited.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_mask(logic [3:0] m);
    cfg_valid <= 1'b1;
    cfg_drive_present_mask <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic add_row(logic op, logic [7:0] val);
    stim_rows.push_back({op, val, 1'b0, res_t'('0)});
  endtask

  task automatic add_pinned_row(logic op, logic [7:0] val, res_t exp);
    stim_rows.push_back({op, val, 1'b1, exp});
  endtask

  // noise byte that cannot start a frame
  function automatic logic [7:0] noise_byte();
    logic [7:0] x;
    x = 8'($urandom);
    if (x == TOK_FIRST) x = 8'h00;
    return x;
  endfunction

  // one random frame. short frames carry an unknown operation or a wrong
  // second token and end back at hunting; the open frame is a read or a
  // write whose payload stops well short of a full sector
  task automatic send_frame(bit open_frame);
    int sel;
    int i;
    int n;
    logic [7:0] drv;
    logic [7:0] opc;
    logic [7:0] trk;
    logic [7:0] sec;
    logic [7:0] x;
    sel = $urandom_range(0, 19);
    steady = ($urandom_range(0, 3) == 0);
    // sender pause until the block has caught up
    if ($urandom_range(0, 5) == 0) drain();
    drv = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    trk = 8'($urandom);
    sec = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
    if (open_frame) begin
      opc = (sel < 10) ? OP_READ : OP_WRITE;
    end else begin
      opc = 8'($urandom);
      if (opc == OP_READ || opc == OP_WRITE) opc = 8'h00;
    end
    n = $urandom_range(0, 2);
    for (i = 0; i < n; i++) feed(1'($urandom_range(0, 1)), noise_byte());
    feed(SRC_SERIAL, TOK_FIRST);
    if (!open_frame && sel >= 17) begin
      // broken frame: wrong second token
      feed(SRC_SERIAL, ($urandom_range(0, 1) == 0) ? TOK_FIRST : 8'h00);
    end else begin
      feed(SRC_SERIAL, TOK_SECOND);
      feed(SRC_SERIAL, drv);
      feed(SRC_SERIAL, opc);
      feed(SRC_SERIAL, trk);
      feed(SRC_SERIAL, sec);
      feed(SRC_SERIAL, 8'($urandom));
      if (opc == OP_READ) begin
        for (i = 0; i < OPEN_PAYLOAD; i++) begin
          // stray serial byte, dropped during the reply
          if ($urandom_range(0, 15) == 0) feed(SRC_SERIAL, 8'($urandom));
          feed(SRC_STORE, 8'($urandom));
        end
      end else if (opc == OP_WRITE) begin
        for (i = 0; i < OPEN_PAYLOAD; i++) begin
          // stray storage byte, ignored outside a read reply
          if ($urandom_range(0, 15) == 0) feed(SRC_STORE, 8'($urandom));
          x = 8'($urandom);
          feed(SRC_SERIAL, x);
        end
      end
    end
    if (!open_frame) settle();
  endtask

  initial begin : stimulus
    int i;
    int f;
    logic [3:0] m;
    stim_row_t r;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, mask still at its reset value of zero
    add_row(SRC_STORE, 8'hFF);             // storage byte while hunting
    add_row(SRC_SERIAL, 8'h00);
    add_row(SRC_SERIAL, TOK_FIRST);
    add_row(SRC_SERIAL, 8'h12);            // wrong second token
    add_row(SRC_SERIAL, TOK_SECOND);       // not a first token, still hunting
    // unknown operation 0xFF with drive, track and sector at their top value too
    add_row(SRC_SERIAL, TOK_FIRST);
    add_row(SRC_SERIAL, TOK_SECOND);
    add_row(SRC_SERIAL, 8'hFF);
    add_row(SRC_SERIAL, 8'hFF);
    add_row(SRC_SERIAL, 8'hFF);
    add_row(SRC_SERIAL, 8'hFF);
    add_pinned_row(SRC_SERIAL, 8'h00,
                   mk_res(RES_BAD_OP, 8'h00, 8'hFF, 8'hFF, 8'hFF, 21'd1109760,
                          1'b0, 1'b0, 1'b1));
    for (i = 0; i < stim_rows.size(); i++) begin
      r = stim_rows[i];
      put_word(r.op, r.val, r.pinned, r.exp);
      idle_gap();
    end
    // back to hunting, then the block goes idle
    settle();
    drain();

    // random part under several mask settings, both extremes among them
    for (i = 0; i < MASK_SETTINGS; i++) begin
      case (i)
        0: m = 4'hF;
        1: m = 4'h0;
        2: m = 4'h5;
        3: m = 4'hA;
        4: m = 4'($urandom_range(0, 15));
        default: m = 4'hF;
      endcase
      write_mask(m);
      for (f = 0; f < FRAMES_PER_MASK; f++) send_frame(1'b0);
      drain();
    end
    // last a read or write that is left open
    send_frame(1'b1);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
